// ===== rtl/wpfm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wpfm_pkg
// Shared types and constants of the windowed pulse frequency meter.
// ----------------------------------------------------------------------------
package wpfm_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_AW = 3;

  localparam logic [DATA_W-1:0] WINDOW_RST = 32'd80000;
  localparam logic [DATA_W-1:0] TICK_RST   = 32'd16000000;

  typedef enum logic {
    CMD_CAPTURE = 1'b0,
    CMD_QUERY   = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_WINDOW_TICKS = 1'b0,
    REG_TICK_RATE    = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_PRIME,
    ST_WALK,
    ST_CHK,
    ST_DIV1,
    ST_DIV2,
    ST_FIN
  } state_t;

endpackage : wpfm_pkg
`default_nettype wire

// ===== rtl/windowed_pulse_frequency_meter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_pulse_frequency_meter
// Stores capture timestamps in a ring and answers speed queries with
// tick_rate / mean(period) over the stamps inside the age window.
//
//   port group   dir      contents
//   in_*         sink     cmd, timestamp (capture or query request)
//   out_*        source   speed_hz, one per query
//   cfg_*        APB      window_ticks @0x0, tick_rate @0x4
//
// Capture: written to the ring in the idle state. Query: start and prime
// steps, one walk step per counted pair (up to RING_DEPTH-1), one more when an old stamp ends
// the walk, up to two divisions (one shared divider), then finish.
// The walk reads one ring entry per cycle from the single RAM read port.
// Reset is synchronous; the ring is not cleared, a fill count masks
// never-written entries as zero. A query result waits in the output
// register while captures keep being taken.
// ----------------------------------------------------------------------------
module windowed_pulse_frequency_meter
  import wpfm_pkg::*;
#(
  parameter int RING_DEPTH = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_cmd,
  input  wire logic [DATA_W-1:0] in_timestamp,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [DATA_W-1:0] out_speed_hz,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output logic      [DATA_W-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int BW = $clog2(RING_DEPTH + 2);
  localparam int CW = $clog2(RING_DEPTH);

  state_t            state_r, state_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [BW-1:0]     fill_r, fill_nxt;
  logic [AW-1:0]     rp_r, rp_nxt;
  logic [BW-1:0]     back_r, back_nxt;
  logic              rd_ok_r;
  logic [DATA_W-1:0] now_r, now_nxt;
  logic [DATA_W-1:0] later_r, later_nxt;
  logic [DATA_W-1:0] sum_r, sum_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_speed_r, out_speed_nxt;
  logic [DATA_W-1:0] window_r, tick_r;

  logic              in_acc;
  logic              ram_we;
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] earlier;
  logic [DATA_W-1:0] age;
  logic [AW-1:0]     rp_dec;
  logic              out_free;
  logic              div_start;
  logic [DATA_W-1:0] div_dividend;
  logic [DATA_W-1:0] div_divisor;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;
  logic              cfg_wr;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RST;
      tick_r   <= TICK_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_paddr[2]))
        REG_WINDOW_TICKS: window_r <= cfg_pwdata;
        REG_TICK_RATE:    tick_r   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(cfg_paddr[2]))
      REG_WINDOW_TICKS: cfg_prdata = window_r;
      REG_TICK_RATE:    cfg_prdata = tick_r;
      default:          cfg_prdata = '0;
    endcase
  end

  // ring storage
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign ram_we   = in_acc & (cmd_t'(in_cmd) == CMD_CAPTURE);

  wpfm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_timestamp),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  wpfm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign earlier  = rd_ok_r ? ram_rdata : '0;
  assign age      = now_r - later_r;
  assign rp_dec   = (rp_r == '0) ? AW'(RING_DEPTH - 1) : rp_r - 1'b1;
  assign out_free = !out_valid_r || out_ready;

  assign div_dividend = (state_r == ST_CHK) ? sum_r : tick_r;
  assign div_divisor  = (state_r == ST_CHK) ? DATA_W'(count_r) : div_quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_ok_r     <= (back_r <= fill_r);
    rp_r        <= rp_nxt;
    back_r      <= back_nxt;
    now_r       <= now_nxt;
    later_r     <= later_nxt;
    sum_r       <= sum_nxt;
    res_r       <= res_nxt;
    out_speed_r <= out_speed_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    rp_nxt        = rp_r;
    back_nxt      = back_r;
    now_nxt       = now_r;
    later_nxt     = later_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    res_nxt       = res_r;
    out_speed_nxt = out_speed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    div_start     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (cmd_t'(in_cmd) == CMD_CAPTURE) begin
            wp_nxt = (wp_r == AW'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
            if (fill_r < BW'(RING_DEPTH)) begin
              fill_nxt = fill_r + 1'b1;
            end
          end else begin
            now_nxt   = in_timestamp;
            rp_nxt    = (wp_r == '0) ? AW'(RING_DEPTH - 1) : wp_r - 1'b1;
            back_nxt  = BW'(1);
            sum_nxt   = '0;
            count_nxt = '0;
            state_nxt = ST_START;
          end
        end
      end
      ST_START: begin
        rp_nxt    = rp_dec;
        back_nxt  = back_r + 1'b1;
        state_nxt = ST_PRIME;
      end
      ST_PRIME: begin
        later_nxt = earlier;
        rp_nxt    = rp_dec;
        back_nxt  = back_r + 1'b1;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (age > window_r) begin
          state_nxt = ST_CHK;
        end else begin
          sum_nxt   = sum_r + (later_r - earlier);
          count_nxt = count_r + 1'b1;
          later_nxt = earlier;
          if (count_r == CW'(RING_DEPTH - 2)) begin
            state_nxt = ST_CHK;
          end else begin
            rp_nxt   = rp_dec;
            back_nxt = back_r + 1'b1;
          end
        end
      end
      ST_CHK: begin
        if (count_r == '0 || sum_r == '0) begin
          res_nxt   = '0;
          state_nxt = ST_FIN;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div_done) begin
          if (div_quo == '0) begin
            res_nxt   = '0;
            state_nxt = ST_FIN;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV2;
          end
        end
      end
      ST_DIV2: begin
        if (div_done) begin
          res_nxt   = div_quo;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_speed_nxt = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_speed_hz = out_speed_r;

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= BW'(RING_DEPTH))
    else $error("fill count beyond ring depth");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(RING_DEPTH - 1))
    else $error("pair count beyond ring depth");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV1 || state_r == ST_DIV2))
    else $error("divider finished outside a division step");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result loaded outside the finish step");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> !in_ready)
    else $error("request taken during a walk");

endmodule : windowed_pulse_frequency_meter
`default_nettype wire

// ===== rtl/wpfm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wpfm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wpfm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : wpfm_ram
`default_nettype wire

// ===== rtl/wpfm_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wpfm_div
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wpfm_div
  import wpfm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic                   done,
  output logic      [DATA_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   trial;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DATA_W-1]};
    trial    = rem_sh - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
      cnt_nxt = CNT_W'(DATA_W);
    end else if (cnt_r != '0) begin
      if (!trial[DATA_W]) begin
        rem_nxt = trial[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule : wpfm_div
`default_nettype wire
